// File: rtl/frame_delta_regression_unit_macros.svh
// Assertion macros shared by the frame delta regression RTL.
`ifndef FRAME_DELTA_REGRESSION_UNIT_MACROS_SVH
`define FRAME_DELTA_REGRESSION_UNIT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define FDR_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define FDR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// File: rtl/fdr_pkg.sv
// Types, constants and the reciprocal table of the frame delta regression unit.
package fdr_pkg;

  localparam int VALUE_BITS = 24;
  localparam int MAX_HALF   = 4;
  localparam int MAX_ORDER  = 16;
  localparam int LINE_DEPTH = 2 * MAX_HALF;

  localparam int POS_W    = 4;
  localparam int HALF_W   = 3;
  localparam int COUNT_W  = 5;
  localparam int FRAMES_W = 4;

  // A tap times a weight of at most MAX_HALF in magnitude.
  localparam int TERM_W = VALUE_BITS + 4;
  // The window sum stays below 20 * 2^23 in magnitude.
  localparam int SUM_W  = VALUE_BITS + 5;
  localparam int MAG_W  = VALUE_BITS + 4;

  // Division by 2D+1 is a multiplication by ceil(2^32 / (2D+1)).
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 32;
  localparam int PROD_W      = MAG_W + RECIP_W;
  localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

  localparam int OUT_BITS    = 26;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_COUNT = 1'b1;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             last;
  } meta_t;

  // A half width of zero always gives a zero sum, so its entry is zero.
  function automatic logic [RECIP_W-1:0] recip(input logic [HALF_W-1:0] half);
    logic [RECIP_W-1:0] r;
    unique case (half)
      3'd1:    r = 31'd1431655766;
      3'd2:    r = 31'd858993460;
      3'd3:    r = 31'd613566757;
      3'd4:    r = 31'd477218589;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/frame_delta_regression_unit.sv
// Top level of the frame delta regression unit: input control, cell chain and window sum.
//
// Takes one coefficient per clock cycle and raises m_axis_tvalid with its delta once the
// transaction that brought in the coefficient D frames later has passed the cell, sum and
// divider registers; the whole path is a pipeline that stalls only while a finished result
// waits on the output. Eight cells, one per past frame, each keep a 16-entry row with valid
// bits, so the start of an utterance clears the history at once and no clearing pass is
// needed. The sum of the nine weighted taps is registered in sum2, and the division by 2D+1
// is a 28 by 31 bit reciprocal multiply through mag_a, prod_b and quotient. Configuration
// writes take effect at once and belong between utterances or while the unit is idle.
`include "frame_delta_regression_unit_macros.svh"

module frame_delta_regression_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_value[23:0]
  input  logic [fdr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // func[0], utterance_start[1]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // delta_value[25:0], coeff_index[29:26], zero[31:30]
  output logic [fdr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // frame_end
  output logic                                m_axis_tlast,
  input  logic                                cfg_we,
  input  logic [fdr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fdr_pkg::COUNT_W-1:0]         cfg_data
);

  localparam int VALUE_BITS = fdr_pkg::VALUE_BITS;
  localparam int LINE_DEPTH = fdr_pkg::LINE_DEPTH;
  localparam int POS_W      = fdr_pkg::POS_W;
  localparam int HALF_W     = fdr_pkg::HALF_W;
  localparam int COUNT_W    = fdr_pkg::COUNT_W;
  localparam int FRAMES_W   = fdr_pkg::FRAMES_W;
  localparam int TERM_W     = fdr_pkg::TERM_W;
  localparam int SUM_W      = fdr_pkg::SUM_W;
  localparam int OUT_BITS   = fdr_pkg::OUT_BITS;

  logic [HALF_W-1:0]    window_half;
  logic [COUNT_W-1:0]   coeff_count;
  logic [HALF_W-1:0]    half_eff;
  logic [COUNT_W-1:0]   count_eff;

  logic [POS_W-1:0]     element_position;
  logic [FRAMES_W-1:0]  frames_seen;

  logic                 advance;
  logic                 in_acc;
  logic                 in_start;
  logic                 in_pad;
  logic signed [VALUE_BITS-1:0] cur;
  logic [POS_W-1:0]     pos_now;
  logic [FRAMES_W-1:0]  frames_now;
  logic [COUNT_W-1:0]   pos_inc;
  logic                 last_now;
  logic                 emit_now;

  logic signed [VALUE_BITS-1:0]      taps [LINE_DEPTH];
  logic signed [TERM_W-1:0]          terms [LINE_DEPTH];
  logic signed [VALUE_BITS+HALF_W:0] cur_prod;
  logic signed [VALUE_BITS+HALF_W:0] cur_neg;

  logic                     v1;
  logic signed [TERM_W-1:0] cur_term;
  fdr_pkg::meta_t           meta1;
  logic [HALF_W-1:0]        half1;

  logic signed [SUM_W-1:0]  sum_c;
  logic                     v2;
  logic signed [SUM_W-1:0]  sum2;
  fdr_pkg::meta_t           meta2;
  logic [HALF_W-1:0]        half2;

  logic signed [OUT_BITS-1:0] delta;
  fdr_pkg::meta_t             out_meta;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_pad        = s_axis_tuser[0];
  assign in_start      = s_axis_tuser[1];

  assign half_eff  = (window_half > HALF_W'(fdr_pkg::MAX_HALF)) ?
                     HALF_W'(fdr_pkg::MAX_HALF) : window_half;
  always_comb begin
    if (coeff_count == '0) begin
      count_eff = COUNT_W'(1);
    end else if (coeff_count > COUNT_W'(fdr_pkg::MAX_ORDER)) begin
      count_eff = COUNT_W'(fdr_pkg::MAX_ORDER);
    end else begin
      count_eff = coeff_count;
    end
  end

  // A start element is coefficient 0 of frame 0 with an empty history.
  assign cur        = in_pad ? '0 : $signed(s_axis_tdata[VALUE_BITS-1:0]);
  assign pos_now    = in_start ? '0 : element_position;
  assign frames_now = in_start ? '0 : frames_seen;
  assign pos_inc    = {1'b0, pos_now} + COUNT_W'(1);
  assign last_now   = pos_inc >= count_eff;
  assign emit_now   = frames_now >= {1'b0, half_eff};

  always_ff @(posedge clk) begin
    if (rst) begin
      window_half <= HALF_W'(2);
      coeff_count <= COUNT_W'(12);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdr_pkg::REG_WINDOW_HALF: window_half <= cfg_data[HALF_W-1:0];
        fdr_pkg::REG_COEFF_COUNT: coeff_count <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_position <= '0;
      frames_seen      <= '0;
    end else if (in_acc) begin
      if (last_now) begin
        element_position <= '0;
        if (frames_now != {FRAMES_W{1'b1}}) begin
          frames_seen <= frames_now + FRAMES_W'(1);
        end else begin
          frames_seen <= frames_now;
        end
      end else begin
        element_position <= pos_inc[POS_W-1:0];
        frames_seen      <= frames_now;
      end
    end
  end

  // Each cell takes its neighbor's old value at this position, so the frames shift by one.
  for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
    fdr_cell #(
      .TAP (i + 1)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (in_acc),
      .clear (in_start),
      .pos   (pos_now),
      .half  (half_eff),
      .din   ((i == 0) ? cur : taps[(i == 0) ? 0 : i - 1]),
      .dout  (taps[i]),
      .term  (terms[i])
    );
  end

  // The current element carries weight -D.
  assign cur_prod = cur * $signed({2'b00, half_eff});
  assign cur_neg  = -cur_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v1 <= in_acc && emit_now;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_term <= cur_neg[TERM_W-1:0];
      meta1    <= {pos_now, last_now};
      half1    <= half_eff;
    end
  end

  always_comb begin
    sum_c = SUM_W'(cur_term);
    for (int k = 0; k < LINE_DEPTH; k++) begin
      sum_c = sum_c + SUM_W'(terms[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sum2  <= sum_c;
      meta2 <= meta1;
      half2 <= half1;
    end
  end

  fdr_recip_div u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (v2),
    .sum       (sum2),
    .half      (half2),
    .in_meta   (meta2),
    .out_valid (m_axis_tvalid),
    .quotient  (delta),
    .out_meta  (out_meta)
  );

  assign m_axis_tdata = {2'b00, out_meta.pos, delta};
  assign m_axis_tlast = out_meta.last;

  `FDR_ASSERT_SAME(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")
  `FDR_ASSERT_NEXT(a_start_resets_count, in_acc && in_start, frames_seen <= FRAMES_W'(1), "frame count not restarted")
  `FDR_ASSERT_NEXT(a_zero_half_emits, in_acc && (half_eff == '0), v1, "element with zero half width gave no result")

endmodule

// File: rtl/fdr_cell.sv
// One cell of the frame delay line: one past frame, its tap and its weighted term.
module fdr_cell #(
  parameter int TAP = 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   shift,
  input  logic                                   clear,
  input  logic [fdr_pkg::POS_W-1:0]              pos,
  input  logic [fdr_pkg::HALF_W-1:0]             half,
  input  logic signed [fdr_pkg::VALUE_BITS-1:0]  din,
  output logic signed [fdr_pkg::VALUE_BITS-1:0]  dout,
  output logic signed [fdr_pkg::TERM_W-1:0]      term
);

  localparam int VALUE_BITS = fdr_pkg::VALUE_BITS;
  localparam int HALF_W     = fdr_pkg::HALF_W;
  localparam int WEIGHT_W   = HALF_W + 2;
  localparam logic [WEIGHT_W-1:0] TAP_POS = WEIGHT_W'(TAP);

  logic signed [VALUE_BITS-1:0]          frame_mem [fdr_pkg::MAX_ORDER];
  logic [fdr_pkg::MAX_ORDER-1:0]         filled;
  logic [fdr_pkg::MAX_ORDER-1:0]         pos_sel;
  logic [WEIGHT_W-1:0]                   twice_half;
  logic signed [WEIGHT_W-1:0]            weight;
  logic signed [VALUE_BITS+WEIGHT_W-1:0] product;

  // An entry never written since the utterance start reads as zero.
  assign dout = (filled[pos] && !clear) ? frame_mem[pos] : '0;

  assign pos_sel = {{(fdr_pkg::MAX_ORDER-1){1'b0}}, 1'b1} << pos;

  // Tap TAP frames back carries weight TAP - D inside the window, zero beyond it.
  assign twice_half = {1'b0, half, 1'b0};
  assign weight     = (TAP_POS <= twice_half) ? $signed(TAP_POS - {2'b00, half}) : '0;
  assign product    = dout * weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (shift) begin
      if (clear) begin
        filled <= pos_sel;
      end else begin
        filled <= filled | pos_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      frame_mem[pos] <= din;
      term           <= product[fdr_pkg::TERM_W-1:0];
    end
  end

endmodule

// File: rtl/fdr_recip_div.sv
// Signed division of the window sum by 2D+1 through a reciprocal multiply, with saturation.
module fdr_recip_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 advance,
  input  logic                                 in_valid,
  input  logic signed [fdr_pkg::SUM_W-1:0]     sum,
  input  logic [fdr_pkg::HALF_W-1:0]           half,
  input  fdr_pkg::meta_t                       in_meta,
  output logic                                 out_valid,
  output logic signed [fdr_pkg::OUT_BITS-1:0]  quotient,
  output fdr_pkg::meta_t                       out_meta
);

  localparam int SUM_W    = fdr_pkg::SUM_W;
  localparam int MAG_W    = fdr_pkg::MAG_W;
  localparam int QUOT_W   = fdr_pkg::QUOT_W;
  localparam int OUT_BITS = fdr_pkg::OUT_BITS;

  logic                          va;
  logic [MAG_W-1:0]              mag_a;
  logic                          neg_a;
  logic [fdr_pkg::RECIP_W-1:0]   recip_a;
  fdr_pkg::meta_t                meta_a;

  logic                          vb;
  logic [fdr_pkg::PROD_W-1:0]    prod_b;
  logic                          neg_b;
  fdr_pkg::meta_t                meta_b;

  logic [SUM_W-1:0]              mag_full;
  logic [QUOT_W-1:0]             quot;
  logic signed [QUOT_W:0]        signed_quot;
  logic signed [OUT_BITS-1:0]    sat_quot;

  assign mag_full = sum[SUM_W-1] ? -sum : sum;

  assign quot        = prod_b[fdr_pkg::PROD_W-1:fdr_pkg::RECIP_SHIFT];
  assign signed_quot = neg_b ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  // Clamp to the output range when the upper bits are not a sign extension.
  always_comb begin
    if (!signed_quot[QUOT_W] && (|signed_quot[QUOT_W-1:OUT_BITS-1])) begin
      sat_quot = {1'b0, {(OUT_BITS-1){1'b1}}};
    end else if (signed_quot[QUOT_W] && !(&signed_quot[QUOT_W-1:OUT_BITS-1])) begin
      sat_quot = {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      sat_quot = signed_quot[OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mag_a    <= mag_full[MAG_W-1:0];
      neg_a    <= sum[SUM_W-1];
      recip_a  <= fdr_pkg::recip(half);
      meta_a   <= in_meta;
      prod_b   <= mag_a * recip_a;
      neg_b    <= neg_a;
      meta_b   <= meta_a;
      quotient <= sat_quot;
      out_meta <= meta_b;
    end
  end

endmodule

// File: tb/sv/frame_delta_checker.sv
// Checker for the frame delta regression unit: predicts deltas and compares output transactions.
`timescale 1ns / 100ps

module frame_delta_checker
  import fdr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic [1:0]             in_user,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [OUT_TDATA_W-1:0] out_data,
  input  logic                   out_last,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data,
  output int                     fail_count,
  output int                     pending
);

  typedef struct packed {
    logic [OUT_BITS-1:0] delta;
    logic [POS_W-1:0]    index;
    logic                frame_end;
  } delta_t;

  logic signed [VALUE_BITS-1:0] history [LINE_DEPTH][MAX_ORDER];
  logic [POS_W-1:0]    in_pos;
  logic [FRAMES_W-1:0] frames_done;
  logic [HALF_W-1:0]   half_reg;
  logic [COUNT_W-1:0]  count_reg;
  delta_t              delta_due_q[$];
  delta_t              got_delta;
  delta_t              due_delta;
  int                  errors = 0;

  task automatic clear_history();
    for (int f = 0; f < LINE_DEPTH; f++)
      for (int c = 0; c < MAX_ORDER; c++)
        history[f][c] = '0;
    in_pos      = '0;
    frames_done = '0;
  endtask

  // Applies one accepted element to the predicted state and queues its delta, if any.
  task automatic step_regression(input logic [IN_TDATA_W-1:0] raw, input logic [1:0] user);
    int               d;
    int               cnt;
    logic [POS_W-1:0] p;
    longint           cur;
    longint           acc;
    longint           quo;
    longint           hi;
    longint           lo;
    logic             last;
    delta_t           e;
    if (user[1])
      clear_history();
    d   = (half_reg > MAX_HALF) ? MAX_HALF : int'(half_reg);
    cnt = (count_reg == 0) ? 1 : ((count_reg > MAX_ORDER) ? MAX_ORDER : int'(count_reg));
    p   = in_pos;
    if (user[0])
      cur = 0;
    else
      cur = longint'($signed(raw[VALUE_BITS-1:0]));
    // The tap a frames back carries weight a - D; the current element carries -D.
    acc = -longint'(d) * cur;
    for (int a = 1; a <= 2 * d; a++)
      acc += longint'(a - d) * longint'(history[a-1][p]);
    quo = acc / longint'(2 * d + 1);
    hi  = (longint'(1) << (OUT_BITS - 1)) - 1;
    lo  = -(longint'(1) << (OUT_BITS - 1));
    if (quo > hi)
      quo = hi;
    if (quo < lo)
      quo = lo;
    last = (int'(p) + 1 >= cnt);
    if (int'(frames_done) >= d) begin
      e.delta     = quo[OUT_BITS-1:0];
      e.index     = p;
      e.frame_end = last;
      delta_due_q.push_back(e);
    end
    for (int a = LINE_DEPTH - 1; a > 0; a--)
      history[a][p] = history[a-1][p];
    history[0][p] = cur[VALUE_BITS-1:0];
    if (last) begin
      in_pos = '0;
      if (frames_done < 4'd15)
        frames_done = frames_done + 1'b1;
    end else begin
      in_pos = p + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_history();
      half_reg  = 3'd2;
      count_reg = 5'd12;
      delta_due_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WINDOW_HALF)
          half_reg = cfg_data[HALF_W-1:0];
        else
          count_reg = cfg_data;
      end
      if (in_valid && in_ready)
        step_regression(in_data, in_user);
      if (out_valid && out_ready) begin
        got_delta.delta     = out_data[OUT_BITS-1:0];
        got_delta.index     = out_data[OUT_BITS+POS_W-1:OUT_BITS];
        got_delta.frame_end = out_last;
        if (delta_due_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected delta transaction: delta=%0d index=%0d frame_end=%0b",
                     $signed(got_delta.delta), got_delta.index, got_delta.frame_end);
        end else begin
          due_delta = delta_due_q.pop_front();
          if (got_delta != due_delta) begin
            errors++;
            if (errors <= 10)
              $display("delta mismatch: expected delta=%0d index=%0d frame_end=%0b,",
                       $signed(due_delta.delta), due_delta.index, due_delta.frame_end,
                       " got delta=%0d index=%0d frame_end=%0b",
                       $signed(got_delta.delta), got_delta.index, got_delta.frame_end);
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= delta_due_q.size();
  end

endmodule

// File: tb/sv/tb_frame_delta_regression_unit.sv
// Testbench top for the frame delta regression unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_frame_delta_regression_unit;
  import fdr_pkg::*;

  localparam int ITEM_TARGET  = 1925;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 400;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // sample_value[23:0]
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  // func[0], utterance_start[1]
  logic [1:0]              s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // delta_value[25:0], coeff_index[29:26], zero[31:30]
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  // frame_end
  logic                    m_axis_tlast;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [COUNT_W-1:0]      cfg_data = '0;

  int fail_count;
  int pending;
  int items_sent = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  bit stall_req  = 1'b0;
  int hold_left  = 0;
  int eff_half   = 2;
  int eff_count  = 12;

  frame_delta_regression_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  frame_delta_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .in_user    (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver: random back-pressure, plus a long hold-off when the stimulus asks for one.
  initial begin
    forever begin
      @(posedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (rx_idle_en && $urandom_range(99) < 37) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [IN_TDATA_W-1:0] pick_value();
    logic [IN_TDATA_W-1:0] v;
    case ($urandom_range(9))
      0:       v = 24'h7FFFFF;
      1:       v = 24'h800000;
      2:       v = 24'($urandom_range(0, 32)) - 24'd16;
      default: v = 24'($urandom);
    endcase
    return v;
  endfunction

  // When tx_idle_en is set, each cycle before the offer is idle with a chance of 37 in a hundred.
  task automatic push_element(input logic func_bit, input logic [IN_TDATA_W-1:0] value,
                              input logic start_bit);
    if (tx_idle_en) begin
      while ($urandom_range(99) < 37) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= {start_bit, func_bit};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering and waits until every predicted delta has left the block.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    do begin
      while (pending != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (pending != 0);
  endtask

  task automatic set_config(input logic [COUNT_W-1:0] half_word,
                            input logic [COUNT_W-1:0] count_word);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW_HALF;
    cfg_data  <= half_word;
    @(posedge clk);
    cfg_index <= REG_COEFF_COUNT;
    cfg_data  <= count_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    eff_half  = (half_word[2:0] > MAX_HALF) ? MAX_HALF : int'(half_word[2:0]);
    eff_count = (count_word == 0) ? 1 :
                ((count_word > MAX_ORDER) ? MAX_ORDER : int'(count_word));
  endtask

  // One utterance: nf frames of real coefficients, then D padding frames.
  // A broken one stops at a random element and may skip its padding.
  task automatic send_utterance(input bit with_start);
    int nf;
    int stop_at;
    int n;
    int room;
    nf      = $urandom_range(1, (eff_count > 8) ? 6 : 18);
    // Keep the total close to the item target.
    room    = (ITEM_TARGET - items_sent) / eff_count;
    if (room >= 1 && nf > room)
      nf = room;
    stop_at = ($urandom_range(99) < 10) ? $urandom_range(1, nf * eff_count) : -1;
    n       = 0;
    for (int f = 0; f < nf; f++) begin
      for (int c = 0; c < eff_count; c++) begin
        if (stop_at >= 0 && n >= stop_at)
          break;
        push_element(1'b0, pick_value(), with_start && n == 0);
        n++;
      end
    end
    if (stop_at < 0 || $urandom_range(1) == 1)
      for (int p = 0; p < eff_half * eff_count; p++)
        push_element(1'b1, 24'($urandom), 1'b0);
  endtask

  initial begin
    int               phase;
    int               r;
    int               n_utt;
    logic [HALF_W-1:0] half_pick;
    logic [COUNT_W-1:0] half_word;
    logic [COUNT_W-1:0] count_word;
    bit               carry_on;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full-scale window at D = 4: strongly positive old frames, strongly negative new ones.
    set_config(5'd4, 5'd1);
    push_element(1'b0, 24'h7FFFFF, 1'b1);
    repeat (3) push_element(1'b0, 24'h7FFFFF, 1'b0);
    push_element(1'b0, 24'h123456, 1'b0);
    repeat (4) push_element(1'b0, 24'h800000, 1'b0);
    repeat (4) push_element(1'b1, 24'h5A5A5A, 1'b0);

    // Two coefficients per frame with a new utterance starting in the middle of a frame.
    set_config(5'd1, 5'd2);
    push_element(1'b0, 24'h7FFFFF, 1'b1);
    push_element(1'b0, 24'h800000, 1'b0);
    push_element(1'b0, 24'h000001, 1'b0);
    push_element(1'b0, 24'hFFFFFF, 1'b1);
    push_element(1'b0, 24'h000002, 1'b0);
    repeat (2) push_element(1'b1, 24'h000000, 1'b0);

    // A window half of zero and a coefficient count of zero.
    set_config(5'd0, 5'd0);
    push_element(1'b0, 24'h7FFFFF, 1'b1);
    push_element(1'b0, 24'h800000, 1'b0);
    push_element(1'b1, 24'h7FFFFF, 1'b0);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      if (phase == 1) begin
        half_word  = 5'b11111;
        count_word = 5'd31;
      end else if (phase == 2) begin
        half_word  = 5'd4;
        count_word = 5'd16;
      end else begin
        r = $urandom_range(99);
        if (r < 5)
          half_pick = 3'd0;
        else if (r < 12)
          half_pick = 3'($urandom_range(5, 7));
        else
          half_pick = 3'($urandom_range(1, 4));
        half_word = {2'($urandom_range(3)), half_pick};
        r = $urandom_range(99);
        if (r < 5)
          count_word = 5'd0;
        else if (r < 12)
          count_word = 5'($urandom_range(17, 31));
        else if (r < 45)
          count_word = 5'($urandom_range(1, 3));
        else
          count_word = 5'($urandom_range(1, 16));
      end
      set_config(half_word, count_word);

      // Phase 3 runs a long stretch with no idling on either side.
      tx_idle_en = (phase != 2 && phase != 3);
      rx_idle_en = (phase != 3);
      if (phase == 2)
        stall_req = 1'b1;
      n_utt = (phase == 3) ? 8 : $urandom_range(1, 3);

      for (int u = 0; u < n_utt && items_sent < ITEM_TARGET; u++) begin
        // Sometimes the previous utterance carries on under the new settings.
        carry_on = (u == 0 && phase > 1 && $urandom_range(99) < 30);
        if ($urandom_range(99) < 12) begin
          repeat ($urandom_range(1, 10))
            push_element(1'($urandom_range(1)), pick_value(), $urandom_range(9) == 0);
        end else begin
          send_utterance(!carry_on);
        end
      end
    end

    wait_drained();
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/fdr_pkg.sv
rtl/fdr_cell.sv
rtl/fdr_recip_div.sv
rtl/frame_delta_regression_unit.sv
tb/sv/frame_delta_checker.sv
tb/sv/tb_frame_delta_regression_unit.sv
